### src/ssrc_pkg.sv
// shared types and constants for the slow start rate controller
// no dependencies; imported by ssrc_div and slow_start_rate_controller
`timescale 1ns / 1ps

package ssrc_pkg;

    // datapath width of bandwidth, threshold and message size
    localparam int DATA_W = 32;

    // request kind codes carried in tuser
    localparam int KIND_W = 2;
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_RESTART  = 2'd0;
    localparam t_kind KIND_DROP     = 2'd1;
    localparam t_kind KIND_INTERVAL = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MESSAGE_SIZE    = 2'd0;
    localparam t_cfg_idx CFG_START_BANDWIDTH = 2'd1;
    localparam t_cfg_idx CFG_START_THRESHOLD = 2'd2;

    // configuration reset values
    localparam logic [DATA_W-1:0] RST_MESSAGE_SIZE    = 32'd1024;
    localparam logic [DATA_W-1:0] RST_START_BANDWIDTH = 32'd1;
    localparam logic [DATA_W-1:0] RST_START_THRESHOLD = {DATA_W{1'b1}};

    // default width of the stored drop sequence number
    localparam int SEQ_WIDTH_DEF = 32;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### src/ssrc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on ssrc_pkg for DATA_W and t_div_status
`timescale 1ns / 1ps

module ssrc_div
    import ssrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output t_div_status       o_status,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W:0]   w_shift;
    logic              w_ge;

    // shift in the next dividend bit and trial subtract
    assign w_shift = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

### src/slow_start_rate_controller.sv
// Slow start / additive increase sender rate controller. A restart (tuser 0),
// a drop report (tuser 1) or an unused kind (tuser 3) is taken and gives no
// result. An interval request (tuser 2) gives one send interval on the master
// side; it runs through the bit-serial divider, which hands the quotient over
// to the sequencer, which then loads the result register; the divider is
// skipped when the bandwidth is zero. The slave side is ready only while no
// request is at work, and a finished interval waits for the result register
// to empty.
// Depends on ssrc_pkg and ssrc_div.
`timescale 1ns / 1ps

module slow_start_rate_controller
    import ssrc_pkg::*;
#(
    parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [31:0] drop_sequence
    input  t_kind             s_axis_tuser,   // [1:0] kind
    // interval stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata    // [31:0] send_interval
);

    // only the bits of drop_sequence that exist are kept
    localparam int SEQ_W = (SEQ_WIDTH < 32) ? SEQ_WIDTH : 32;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;

    logic [DATA_W-1:0] r_msg_size;
    logic [DATA_W-1:0] r_start_bw;
    logic [DATA_W-1:0] r_start_th;

    logic [DATA_W-1:0] r_bw;
    logic [DATA_W-1:0] n_bw;
    logic [DATA_W-1:0] r_th;
    logic [DATA_W-1:0] n_th;
    logic [SEQ_W-1:0]  r_last_seq;
    logic [SEQ_W-1:0]  n_last_seq;
    logic [1:0]        r_drop_cnt;
    logic [1:0]        n_drop_cnt;
    logic              r_bw_zero;
    logic              n_bw_zero;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [DATA_W-1:0] n_out_data;

    logic              w_accept;
    logic              w_div_start;
    t_div_status       w_div_status;
    logic [DATA_W-1:0] w_quotient;
    logic [SEQ_W-1:0]  w_seq;
    logic [1:0]        w_cnt_base;
    logic [1:0]        w_cnt_next;
    logic [DATA_W-1:0] w_bw_grown;
    logic              w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_seq         = s_axis_tdata[SEQ_W-1:0];
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // drop count update for a report
    assign w_cnt_base = (w_seq != r_last_seq) ? 2'd0 : r_drop_cnt;
    assign w_cnt_next = (w_cnt_base < 2'd2) ? (w_cnt_base + 2'd1) : w_cnt_base;

    // bandwidth growth: double below threshold, else add one, saturating
    always_comb begin
        if (r_bw < r_th) begin
            w_bw_grown = r_bw[DATA_W-1] ? {DATA_W{1'b1}} : {r_bw[DATA_W-2:0], 1'b0};
        end else begin
            w_bw_grown = (r_bw == {DATA_W{1'b1}}) ? r_bw : (r_bw + 1'b1);
        end
    end

    assign w_div_start = w_accept && (s_axis_tuser == KIND_INTERVAL) && (r_bw != '0);

    ssrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_msg_size),
        .i_divisor  (r_bw),
        .o_status   (w_div_status),
        .o_quotient (w_quotient)
    );

    // sequencer and state update
    always_comb begin
        n_state     = r_state;
        n_bw        = r_bw;
        n_th        = r_th;
        n_last_seq  = r_last_seq;
        n_drop_cnt  = r_drop_cnt;
        n_bw_zero   = r_bw_zero;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (s_axis_tuser == KIND_RESTART) begin
                        n_bw       = r_start_bw;
                        n_th       = r_start_th;
                        n_last_seq = '0;
                        n_drop_cnt = 2'd0;
                    end else if (s_axis_tuser == KIND_DROP) begin
                        n_last_seq = w_seq;
                        n_drop_cnt = w_cnt_next;
                        if (w_cnt_next == 2'd1) begin
                            n_th = {1'b0, r_bw[DATA_W-1:1]};
                            n_bw = {1'b0, r_bw[DATA_W-1:1]};
                        end
                    end else if (s_axis_tuser == KIND_INTERVAL) begin
                        n_bw_zero = (r_bw == '0);
                        n_bw      = w_bw_grown;
                        n_state   = (r_bw == '0) ? ST_DONE : ST_DIV;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_status.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_bw_zero || (w_quotient == '0)) begin
                        n_out_data = DATA_W'(1);
                        n_bw       = r_msg_size;
                    end else begin
                        n_out_data = w_quotient;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bw        <= '0;
            r_th        <= '0;
            r_last_seq  <= '0;
            r_drop_cnt  <= 2'd0;
            r_out_valid <= 1'b0;
            r_bw_zero   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bw        <= n_bw;
            r_th        <= n_th;
            r_last_seq  <= n_last_seq;
            r_drop_cnt  <= n_drop_cnt;
            r_out_valid <= n_out_valid;
            r_bw_zero   <= n_bw_zero;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_size <= RST_MESSAGE_SIZE;
            r_start_bw <= RST_START_BANDWIDTH;
            r_start_th <= RST_START_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MESSAGE_SIZE:    r_msg_size <= i_cfg_data;
                CFG_START_BANDWIDTH: r_start_bw <= i_cfg_data;
                CFG_START_THRESHOLD: r_start_th <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### verif/tb_top.sv
// testbench for slow_start_rate_controller: directed and random request streams
// checked against send intervals predicted from bandwidth, threshold and drop state
// depends on ssrc_pkg and the rtl of slow_start_rate_controller
`timescale 1ns / 1ps

module tb_top;
    import ssrc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 31;
    localparam longint RUN_LIMIT_NS = 5_000_000;
    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] TOP_BIT  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_kind    KIND_UNUSED = 2'd3;
    localparam t_cfg_idx CFG_UNUSED  = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    t_cfg_idx          i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;
    t_kind             s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;

    // predicted controller state and register copies
    logic [DATA_W-1:0] rate_bw;
    logic [DATA_W-1:0] rate_thr;
    logic [31:0]       rate_last_seq;
    logic [1:0]        rate_drops;
    logic [DATA_W-1:0] cfg_msg_size;
    logic [DATA_W-1:0] cfg_start_bw;
    logic [DATA_W-1:0] cfg_start_thr;

    logic [DATA_W-1:0] interval_q[$];
    int                mismatches;
    bit                tx_steady;
    bit                rx_steady;
    bit                rx_hold_req;

    slow_start_rate_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] drop_sequence
        .s_axis_tuser  (s_axis_tuser),   // [1:0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [31:0] send_interval
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // mismatch reporting
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // update register copies on a write
    function automatic void track_config(input t_cfg_idx idx, input logic [DATA_W-1:0] data);
        case (idx)
            CFG_MESSAGE_SIZE:    cfg_msg_size  = data;
            CFG_START_BANDWIDTH: cfg_start_bw  = data;
            CFG_START_THRESHOLD: cfg_start_thr = data;
            default: ;
        endcase
    endfunction

    // advance the rate state for one request, queue the interval it answers
    function automatic void predict_interval(input t_kind kind, input logic [31:0] seq);
        logic [DATA_W-1:0] prev;
        logic [DATA_W-1:0] quot;
        case (kind)
            KIND_RESTART: begin
                rate_bw       = cfg_start_bw;
                rate_thr      = cfg_start_thr;
                rate_last_seq = '0;
                rate_drops    = '0;
            end
            KIND_DROP: begin
                if (seq != rate_last_seq) begin
                    rate_drops    = '0;
                    rate_last_seq = seq;
                end
                if (rate_drops < 2'd2)
                    rate_drops++;
                // only the first report of a sequence halves the rate
                if (rate_drops == 2'd1) begin
                    rate_thr = rate_bw >> 1;
                    rate_bw  = rate_thr;
                end
            end
            KIND_INTERVAL: begin
                prev = rate_bw;
                if (rate_bw < rate_thr)
                    rate_bw = (rate_bw > (ALL_ONES >> 1)) ? ALL_ONES : rate_bw << 1;
                else
                    rate_bw = (rate_bw == ALL_ONES) ? ALL_ONES : rate_bw + 1'b1;
                quot = (prev == '0) ? '0 : cfg_msg_size / prev;
                // zero bandwidth or zero quotient falls back to message size
                if (quot == '0) begin
                    rate_bw = cfg_msg_size;
                    quot    = 1;
                end
                interval_q.push_back(quot);
            end
            default: ;
        endcase
    endfunction

    // send one request, predict at acceptance
    task automatic send_req(input t_kind kind, input logic [31:0] seq);
        @(negedge i_clk);
        while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seq;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_interval(kind, seq);
    endtask

    // stop offering and wait for every pending interval
    task automatic wait_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (interval_q.size() != 0)
            @(posedge i_clk);
    endtask

    // idle block: results drained and any silent request finished
    task automatic go_quiet();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        track_config(idx, data);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] msg, input logic [DATA_W-1:0] bw,
                              input logic [DATA_W-1:0] thr);
        go_quiet();
        write_reg(CFG_MESSAGE_SIZE, msg);
        write_reg(CFG_START_BANDWIDTH, bw);
        write_reg(CFG_START_THRESHOLD, thr);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mixed traffic; unused kinds are not counted
    task automatic random_traffic(input int n_items);
        int          sent;
        int          pick;
        logic [31:0] seq;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            seq  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 5);
            if (pick < 8) begin
                send_req(KIND_UNUSED, $urandom());
            end else begin
                sent++;
                if (pick < 18)
                    send_req(KIND_RESTART, $urandom());
                else if (pick < 43)
                    send_req(KIND_DROP, seq);
                else
                    send_req(KIND_INTERVAL, $urandom());
            end
        end
    endtask

    // result checker
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (interval_q.size() == 0)
                    report_mismatch("unexpected send_interval", m_axis_tdata, '0);
                else if (m_axis_tdata !== interval_q[0])
                    report_mismatch("send_interval", m_axis_tdata, interval_q.pop_front());
                else
                    void'(interval_q.pop_front());
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rx_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // zero bandwidth out of reset, drop matching the cleared sequence, unused kind
    task automatic test_reset_state();
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_UNUSED, ALL_ONES);
        send_req(KIND_DROP, '0);
        send_req(KIND_DROP, '0);
        send_req(KIND_INTERVAL, '0);
    endtask

    // slow start growth, repeated and new drop reports, sequence extremes
    task automatic test_slow_start_drops();
        send_req(KIND_RESTART, '0);
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_DROP, ALL_ONES);
        send_req(KIND_DROP, ALL_ONES);
        send_req(KIND_DROP, 32'h5555_5555);
        send_req(KIND_INTERVAL, '0);
    endtask

    // doubling and increment saturate at all ones; unused register index ignored
    task automatic test_saturation();
        set_config(ALL_ONES, TOP_BIT, ALL_ONES);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        send_req(KIND_RESTART, '0);
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_INTERVAL, '0);
    endtask

    // bandwidth above message size gives a zero quotient
    task automatic test_zero_quotient();
        set_config(32'd1, ALL_ONES, ALL_ONES);
        send_req(KIND_RESTART, '0);
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_INTERVAL, '0);
    endtask

    // zero start bandwidth, and a drop report that halves to zero
    task automatic test_zero_bandwidth();
        set_config(32'd1000, '0, '0);
        send_req(KIND_RESTART, '0);
        send_req(KIND_INTERVAL, '0);
        send_req(KIND_RESTART, '0);
        send_req(KIND_DROP, 32'd7);
        send_req(KIND_INTERVAL, '0);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        set_config(RST_MESSAGE_SIZE, RST_START_BANDWIDTH, RST_START_THRESHOLD);
        send_req(KIND_RESTART, '0);
        rx_hold_req = 1'b1;
        repeat (6) send_req(KIND_INTERVAL, '0);
        send_req(KIND_DROP, 32'd3);
        repeat (6) send_req(KIND_INTERVAL, '0);
    endtask

    // sender pauses until all intervals are back
    task automatic test_drain_pause();
        random_traffic(10);
        wait_results();
        random_traffic(10);
    endtask

    // phases over several register settings, the last without any idling
    task automatic test_random_phases();
        int p;
        for (p = 0; p < 7; p++) begin
            case (p)
                0: set_config(RST_MESSAGE_SIZE, RST_START_BANDWIDTH, RST_START_THRESHOLD);
                1: set_config(32'd1, '0, '0);
                2: set_config(ALL_ONES, ALL_ONES, ALL_ONES);
                3: set_config($urandom_range(1, ALL_ONES), $urandom_range(0, 16),
                              $urandom_range(0, 4096));
                4: set_config($urandom_range(1, ALL_ONES), $urandom(), $urandom());
                5: set_config($urandom_range(1, 1000), $urandom_range(0, 8), ALL_ONES);
                default: set_config($urandom_range(1, ALL_ONES), $urandom_range(0, 64),
                                    $urandom_range(0, 100000));
            endcase
            tx_steady = (p == 6);
            rx_steady = (p == 6);
            send_req(KIND_RESTART, $urandom());
            random_traffic(50);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_MESSAGE_SIZE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_RESTART;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        rx_hold_req   = 1'b0;
        rate_bw       = '0;
        rate_thr      = '0;
        rate_last_seq = '0;
        rate_drops    = '0;
        cfg_msg_size  = RST_MESSAGE_SIZE;
        cfg_start_bw  = RST_START_BANDWIDTH;
        cfg_start_thr = RST_START_THRESHOLD;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_slow_start_drops();
        test_saturation();
        test_zero_quotient();
        test_zero_bandwidth();
        test_backpressure();
        test_drain_pause();
        test_random_phases();

        go_quiet();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
src/ssrc_pkg.sv
src/ssrc_div.sv
src/slow_start_rate_controller.sv
verif/tb_top.sv
